FILE: hdl/lru_pkg.sv
// Shared types and codes for the true-LRU replacement block.
// No dependencies; used by lru_replacement_per_set.
`default_nettype none

package lru_pkg;

  localparam int unsigned VICTIM_W  = 4;
  localparam int unsigned SET_IN_W  = 10;
  localparam int unsigned WAY_IN_W  = 4;
  localparam int unsigned MASK_W    = 16;
  localparam int unsigned MOD_SHIFT = 20;

  localparam logic MODE_QUERY  = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_ADDR  = 4'b0100,
    ST_EVAL  = 4'b1000
  } state_t;

endpackage

`default_nettype wire

FILE: hdl/lru_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lru_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/lru_replacement_per_set.sv
// True-LRU age keeper for a set-associative cache: one age row per set in RAM.
// Depends on lru_pkg and lru_ram.
`default_nettype none

// A request is taken when start is high and busy is low. Each request goes through
// set reduction (reciprocal multiply), RAM read of the set's age row, then either
// the victim pick or the age write-back. A query returns one result on
// victim_way/no_victim, marked by a one-cycle done pulse registered out of the EVAL
// state, which follows the ADDR state; the receiver cannot stall it. An update
// returns nothing. After reset busy stays high while the age RAM is initialized
// row by row.

module lru_replacement_per_set #(
  parameter int WAYS = 16,
  parameter int SETS = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                mode,
  input  wire logic [lru_pkg::SET_IN_W-1:0]        set_index,
  input  wire logic [lru_pkg::WAY_IN_W-1:0]        way_index,
  input  wire logic [lru_pkg::MASK_W-1:0]          valid_mask,
  input  wire logic                                is_writeback,
  input  wire logic                                was_hit,
  output logic                                     done,
  output logic      [lru_pkg::VICTIM_W-1:0]        victim_way,
  output logic                                     no_victim
);

  localparam int AGE_W   = $clog2(WAYS);
  localparam int WAY_W   = $clog2(WAYS);
  localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int ROW_W   = WAYS * AGE_W;
  localparam int RECIP_W = 21;
  localparam int PROD_W  = lru_pkg::SET_IN_W + RECIP_W;
  localparam int QD_W    = 27;
  localparam longint MOD_RECIP = ((64'd1 << lru_pkg::MOD_SHIFT) + SETS - 1) / SETS;

  typedef logic [WAYS-1:0][AGE_W-1:0] row_t;

  lru_pkg::state_t state, state_next;

  logic [SET_W-1:0]               clr_cnt;
  logic                           req_mode;
  logic [lru_pkg::SET_IN_W-1:0]   req_set;
  logic [lru_pkg::WAY_IN_W-1:0]   req_way;
  logic [lru_pkg::MASK_W-1:0]     req_mask;
  logic                           req_wb;
  logic                           req_hit;
  logic [lru_pkg::SET_IN_W-1:0]   quot;
  logic [SET_W-1:0]               set_addr;

  logic [PROD_W-1:0]              prod;
  logic [QD_W-1:0]                qd;
  logic [lru_pkg::SET_IN_W:0]     rem_raw;
  logic [lru_pkg::SET_IN_W:0]     rem_fix;
  logic [SET_W+lru_pkg::SET_IN_W:0] rem_ext;
  logic [SET_W-1:0]               set_mod;

  row_t                           rd_row;
  row_t                           new_row;
  row_t                           init_row;
  logic [ROW_W-1:0]               rdata;
  logic                           mem_we;
  logic [SET_W-1:0]               mem_waddr;
  logic [ROW_W-1:0]               mem_wdata;

  logic [WAY_W+lru_pkg::WAY_IN_W-1:0] way_ext;
  logic [WAY_W-1:0]               touch_idx;
  logic [AGE_W-1:0]               touch_age;
  logic                           upd_ok;

  logic [WAYS+lru_pkg::MASK_W-1:0] mask_ext;
  logic [WAYS-1:0]                valid_w;
  logic                           inv_found;
  logic [WAY_W-1:0]               inv_idx;
  logic                           old_found;
  logic [WAY_W-1:0]               old_idx;
  logic [WAY_W-1:0]               pick_idx;
  logic [WAY_W+lru_pkg::VICTIM_W-1:0] pick_ext;

  // Set reduction: quotient by reciprocal, then remainder with one correction.
  assign prod    = PROD_W'(set_index) * PROD_W'(MOD_RECIP);
  assign qd      = QD_W'(quot) * QD_W'(SETS);
  assign rem_raw = {1'b0, req_set} - qd[lru_pkg::SET_IN_W:0];
  assign rem_fix = (QD_W'(rem_raw) >= QD_W'(SETS))
                 ? rem_raw - (lru_pkg::SET_IN_W+1)'(SETS) : rem_raw;
  assign rem_ext = {{SET_W{1'b0}}, rem_fix};
  assign set_mod = rem_ext[SET_W-1:0];

  assign rd_row    = row_t'(rdata);
  assign way_ext   = {{WAY_W{1'b0}}, req_way};
  assign touch_idx = way_ext[WAY_W-1:0];
  assign touch_age = rd_row[touch_idx];
  assign upd_ok    = (req_mode == lru_pkg::MODE_UPDATE) && !(req_wb && req_hit)
                     && (32'(req_way) < 32'(WAYS));

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      init_row[w] = AGE_W'(w);
      if (w == int'(touch_idx)) begin
        new_row[w] = '0;
      end else if (rd_row[w] < touch_age) begin
        new_row[w] = rd_row[w] + AGE_W'(1);
      end else begin
        new_row[w] = rd_row[w];
      end
    end
  end

  assign mask_ext = {{WAYS{1'b1}}, req_mask};
  assign valid_w  = mask_ext[WAYS-1:0];

  always_comb begin
    inv_found = 1'b0;
    inv_idx   = '0;
    old_found = 1'b0;
    old_idx   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!valid_w[w]) begin
        inv_found = 1'b1;
        inv_idx   = WAY_W'(w);
      end
      if (rd_row[w] == AGE_W'(WAYS - 1)) begin
        old_found = 1'b1;
        old_idx   = WAY_W'(w);
      end
    end
  end

  assign pick_idx = inv_found ? inv_idx : (old_found ? old_idx : '0);
  assign pick_ext = {{lru_pkg::VICTIM_W{1'b0}}, pick_idx};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = set_addr;
    mem_wdata = ROW_W'(new_row);
    unique case (state)
      lru_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = ROW_W'(init_row);
      end
      lru_pkg::ST_EVAL: begin
        mem_we = upd_ok;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  lru_ram #(
    .WIDTH(ROW_W),
    .DEPTH(SETS)
  ) u_age_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(set_mod),
    .rdata(rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      lru_pkg::ST_CLEAR: begin
        if (clr_cnt == SET_W'(SETS - 1)) begin
          state_next = lru_pkg::ST_IDLE;
        end
      end
      lru_pkg::ST_IDLE: begin
        if (start) begin
          state_next = lru_pkg::ST_ADDR;
        end
      end
      lru_pkg::ST_ADDR: begin
        state_next = lru_pkg::ST_EVAL;
      end
      lru_pkg::ST_EVAL: begin
        state_next = lru_pkg::ST_IDLE;
      end
      default: begin
        state_next = lru_pkg::ST_CLEAR;
      end
    endcase
  end

  assign busy = (state != lru_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= lru_pkg::ST_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == lru_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + SET_W'(1);
      end
      done <= (state == lru_pkg::ST_EVAL) && (req_mode == lru_pkg::MODE_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (state == lru_pkg::ST_IDLE && start) begin
      req_mode <= mode;
      req_set  <= set_index;
      req_way  <= way_index;
      req_mask <= valid_mask;
      req_wb   <= is_writeback;
      req_hit  <= was_hit;
      quot     <= prod[lru_pkg::MOD_SHIFT +: lru_pkg::SET_IN_W];
    end
    if (state == lru_pkg::ST_ADDR) begin
      set_addr <= set_mod;
    end
    if (state == lru_pkg::ST_EVAL) begin
      victim_way <= pick_ext[lru_pkg::VICTIM_W-1:0];
      no_victim  <= !inv_found && !old_found;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == lru_pkg::ST_EVAL && req_mode == lru_pkg::MODE_QUERY))
    else $error("result strobe without a query in evaluation");

  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == lru_pkg::ST_CLEAR || state == lru_pkg::ST_EVAL))
    else $error("age RAM written outside init or write-back");

  assert property (@(posedge clk) disable iff (rst)
    done |-> !no_victim)
    else $error("age row lost its oldest way");

  assert property (@(posedge clk) disable iff (rst)
    (state == lru_pkg::ST_ADDR) |-> $past(start && !busy))
    else $error("read issued without an accepted request");

endmodule

`default_nettype wire
